// ===== rtl/core/tfst_pkg.sv =====
// Shared constants, codes and helpers for the touch frame slot tracker.
// Depends on nothing; imported by the tracker core.
`default_nettype none

package tfst_pkg;

  // Frame layout
  localparam int FINGERS     = 5;
  localparam int REC_BASE    = 3;
  localparam int REC_SIZE    = 6;
  localparam int STORE_DEPTH = REC_BASE + REC_SIZE * FINGERS + 1;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int BCNT_W      = $clog2(STORE_DEPTH + 1);

  // Field widths
  localparam int ID_W    = 4;
  localparam int EXT_W   = 13;
  localparam int COORD_W = 12;

  // Slot walk counter holds 0..FINGERS, record index 0..FINGERS-1
  localparam int FCNT_W = $clog2(FINGERS + 1);
  localparam int FIDX_W = (FINGERS > 1) ? $clog2(FINGERS) : 1;

  // Decode pass: byte 1, byte 2, then status and id byte of each record
  localparam int RD_N  = 2 + 2 * FINGERS;
  localparam int RDC_W = $clog2(RD_N + 1);

  // Second record used by the resume check
  localparam int Z1_IDX = (FINGERS > 1) ? 1 : 0;

  localparam logic [7:0] WIDTH_FIXED = 8'd100;

  typedef logic [1:0] kind_t;
  localparam kind_t EV_RELEASE = 2'd0;
  localparam kind_t EV_CONTACT = 2'd1;
  localparam kind_t EV_SYNC    = 2'd2;
  localparam kind_t EV_IGNORED = 2'd3;

  typedef logic [1:0] func_t;
  localparam func_t FN_BYTE    = 2'd0;
  localparam func_t FN_RESUME  = 2'd1;
  localparam func_t FN_SUSPEND = 2'd2;

  localparam logic [1:0] ST_DOWN = 2'd0;
  localparam logic [1:0] ST_MOVE = 2'd2;

  localparam logic CFG_X_EXTENT = 1'b0;
  localparam logic CFG_Y_EXTENT = 1'b1;

  // Store address of byte 0 of a point record
  function automatic logic [ADDR_W-1:0] rec_addr(input logic [FIDX_W-1:0] idx);
    rec_addr = ADDR_W'(REC_BASE) + ADDR_W'(REC_SIZE) * ADDR_W'(idx);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tfst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the frame store.
`default_nettype none

module tfst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 34,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/touch_frame_slot_tracker_core.sv =====
// Touch frame slot tracker top level: byte intake, frame store and slot sequencer.
// Depends on tfst_pkg and tfst_ram.
`default_nettype none

// The frame-end byte starts a sequencer that reads the frame store through
// its single read port, one byte a cycle: a decode pass, a resume check,
// then a slot walk with nothing for an id with no event, a release from the
// walk step, and for a contact a walk step, record reads, two passes through
// the shared mirror subtractor and an emit; a sync word ends a walk that
// emitted a word. A failed resume check, or an underflow with a resume
// pending, ends the run with a frame-ignored word. A suspend notice emits a
// release per slot id, then a sync word. Any cycle that emits a word waits
// while the output register is full and stalled. in_stall stays high until
// the whole run has been handed to the output register.
module touch_frame_slot_tracker_core (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // configuration
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_index,
  input  wire logic [tfst_pkg::EXT_W-1:0] cfg_wdata,
  // input channel
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [1:0]              in_func,
  input  wire logic [7:0]              in_frame_byte,
  input  wire logic                    in_frame_end,
  // result channel
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [1:0]                   out_event_kind,
  output logic [3:0]                   out_slot,
  output logic [11:0]                  out_pos_x,
  output logic [11:0]                  out_pos_y,
  output logic [7:0]                   out_touch_width,
  output logic                         out_out_of_range,
  output logic                         out_last
);

  import tfst_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_WALK  = 4'd3;
  localparam logic [3:0] S_CRD   = 4'd4;
  localparam logic [3:0] S_MX    = 4'd5;
  localparam logic [3:0] S_MY    = 4'd6;
  localparam logic [3:0] S_CEMIT = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;
  localparam logic [3:0] S_SUSP  = 4'd9;
  localparam logic [3:0] S_IGN   = 4'd10;

  // Control state
  logic [3:0]        state_r, state_nxt;
  logic [BCNT_W-1:0] byte_count_r, byte_count_nxt;
  logic              prior_valid_r [FINGERS];
  logic              prior_valid_nxt [FINGERS];
  logic [ID_W-1:0]   prior_id_r [FINGERS];
  logic [ID_W-1:0]   prior_id_nxt [FINGERS];
  logic              resume_r, resume_nxt;
  logic [EXT_W-1:0]  x_ext_r, x_ext_nxt;
  logic [EXT_W-1:0]  y_ext_r, y_ext_nxt;
  logic [RDC_W-1:0]  rdc_r, rdc_nxt;
  logic [FCNT_W-1:0] slot_r, slot_nxt;
  logic [FCNT_W-1:0] index_r, index_nxt;
  logic              any_r, any_nxt;
  logic [2:0]        crd_r, crd_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Working payload
  logic              cur_valid_r [FINGERS];
  logic              cur_valid_nxt [FINGERS];
  logic [ID_W-1:0]   cur_id_r [FINGERS];
  logic [ID_W-1:0]   cur_id_nxt [FINGERS];
  logic              b1_nz_r, b1_nz_nxt;
  logic [7:0]        b2_r, b2_nxt;
  logic [7:0]        rb_r [4];
  logic [7:0]        rb_nxt [4];
  logic [COORD_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic              under_r, under_nxt, over_r, over_nxt;

  // Output register payload
  kind_t             o_kind_r, o_kind_nxt;
  logic [ID_W-1:0]   o_slot_r, o_slot_nxt;
  logic [COORD_W-1:0] o_px_r, o_px_nxt, o_py_r, o_py_nxt;
  logic [7:0]        o_w_r, o_w_nxt;
  logic              o_oor_r, o_oor_nxt, o_last_r, o_last_nxt;

  // Frame store ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_rdata;

  tfst_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_frame_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic in_acc;
  logic out_free;
  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // Store write at the running byte count, dropped once the store is full
  assign ram_we    = in_acc && (in_func == FN_BYTE) &&
                     (byte_count_r < BCNT_W'(STORE_DEPTH));
  assign ram_waddr = byte_count_r[ADDR_W-1:0];

  // Decode pass address and consume index
  logic [RDC_W-1:0]  rd_k2, dk2;
  logic [FIDX_W-1:0] rec_sat;
  assign rd_k2 = rdc_r - RDC_W'(2);
  assign dk2   = rdc_r - RDC_W'(3);
  assign rec_sat = (index_r < FCNT_W'(FINGERS)) ? index_r[FIDX_W-1:0] :
                                                  FIDX_W'(FINGERS - 1);

  always_comb begin
    ram_raddr = '0;
    if (state_r == S_DEC) begin
      if (rdc_r == RDC_W'(0)) begin
        ram_raddr = ADDR_W'(1);
      end else if (rdc_r == RDC_W'(1)) begin
        ram_raddr = ADDR_W'(2);
      end else begin
        ram_raddr = rec_addr(rd_k2[FIDX_W:1]) + (rd_k2[0] ? ADDR_W'(2) : ADDR_W'(0));
      end
    end else if (state_r == S_CRD) begin
      ram_raddr = rec_addr(rec_sat) + ADDR_W'(crd_r[1:0]);
    end
  end

  // Presence of the walked slot id now and in the kept ids
  logic cur_hit, prev_hit;
  always_comb begin
    cur_hit  = 1'b0;
    prev_hit = 1'b0;
    for (int i = 0; i < FINGERS; i++) begin
      if (cur_valid_r[i] && cur_id_r[i] == ID_W'(slot_r)) cur_hit = 1'b1;
      if (prior_valid_r[i] && prior_id_r[i] == ID_W'(slot_r)) prev_hit = 1'b1;
    end
  end

  // Shared mirror unit: extent - v - 1 with underflow and clamp
  logic [EXT_W-1:0]   mir_ext;
  logic [COORD_W-1:0] mir_v;
  logic [EXT_W:0]     mir_diff;
  logic               mir_under, mir_over;
  logic [COORD_W-1:0] mir_val;
  always_comb begin
    if (state_r == S_MX) begin
      mir_ext = x_ext_r;
      mir_v   = {rb_r[2][3:0], rb_r[3]};
    end else begin
      mir_ext = y_ext_r;
      mir_v   = {rb_r[0][3:0], rb_r[1]};
    end
    mir_diff  = {1'b0, mir_ext} - {2'b00, mir_v} - (EXT_W+1)'(1);
    mir_under = mir_diff[EXT_W];
    mir_over  = !mir_diff[EXT_W] && mir_diff[EXT_W-1];
    mir_val   = mir_under ? '0 : (mir_over ? '1 : mir_diff[COORD_W-1:0]);
  end

  logic resume_bad;
  assign resume_bad = ((cur_valid_r[0] && cur_id_r[0] == '0) &&
                       ((FINGERS > 1) && cur_valid_r[Z1_IDX] && cur_id_r[Z1_IDX] == '0)) ||
                      b1_nz_r || (b2_r > 8'(FINGERS));

  // Sequencer
  always_comb begin
    logic emit;
    kind_t e_kind;
    logic [ID_W-1:0] e_slot;
    logic e_last;

    emit   = 1'b0;
    e_kind = EV_SYNC;
    e_slot = '0;
    e_last = 1'b0;

    state_nxt      = state_r;
    byte_count_nxt = byte_count_r;
    prior_valid_nxt = prior_valid_r;
    prior_id_nxt   = prior_id_r;
    resume_nxt     = resume_r;
    x_ext_nxt      = x_ext_r;
    y_ext_nxt      = y_ext_r;
    rdc_nxt        = rdc_r;
    slot_nxt       = slot_r;
    index_nxt      = index_r;
    any_nxt        = any_r;
    crd_nxt        = crd_r;
    cur_valid_nxt  = cur_valid_r;
    cur_id_nxt     = cur_id_r;
    b1_nz_nxt      = b1_nz_r;
    b2_nxt         = b2_r;
    rb_nxt         = rb_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    under_nxt      = under_r;
    over_nxt       = over_r;

    // Configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_EXTENT: x_ext_nxt = cfg_wdata;
        CFG_Y_EXTENT: y_ext_nxt = cfg_wdata;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_func)
            FN_BYTE: begin
              if (ram_we) byte_count_nxt = byte_count_r + BCNT_W'(1);
              if (in_frame_end) begin
                byte_count_nxt = '0;
                rdc_nxt   = '0;
                slot_nxt  = '0;
                index_nxt = '0;
                any_nxt   = 1'b0;
                state_nxt = S_DEC;
              end
            end
            FN_RESUME: resume_nxt = 1'b1;
            FN_SUSPEND: begin
              slot_nxt  = '0;
              state_nxt = S_SUSP;
            end
            default: ;
          endcase
        end
      end

      S_DEC: begin
        // Take the byte read in the previous cycle
        if (rdc_r == RDC_W'(1)) begin
          b1_nz_nxt = (ram_rdata != 8'd0);
        end else if (rdc_r == RDC_W'(2)) begin
          b2_nxt = ram_rdata;
        end else if (rdc_r != RDC_W'(0)) begin
          if (!dk2[0]) begin
            cur_valid_nxt[dk2[FIDX_W:1]] = (ram_rdata[7:6] == ST_DOWN) ||
                                           (ram_rdata[7:6] == ST_MOVE);
          end else begin
            cur_id_nxt[dk2[FIDX_W:1]] = ram_rdata[7:4];
          end
        end
        if (rdc_r == RDC_W'(RD_N)) begin
          state_nxt = S_CHK;
        end else begin
          rdc_nxt = rdc_r + RDC_W'(1);
        end
      end

      S_CHK: begin
        state_nxt = (resume_r && resume_bad) ? S_IGN : S_WALK;
      end

      S_WALK: begin
        if (slot_r == FCNT_W'(FINGERS)) begin
          state_nxt = S_DONE;
        end else if (cur_hit) begin
          crd_nxt   = '0;
          state_nxt = S_CRD;
        end else if (prev_hit) begin
          if (out_free) begin
            emit     = 1'b1;
            e_kind   = EV_RELEASE;
            e_slot   = ID_W'(slot_r);
            slot_nxt = slot_r + FCNT_W'(1);
            any_nxt  = 1'b1;
          end
        end else begin
          slot_nxt = slot_r + FCNT_W'(1);
        end
      end

      S_CRD: begin
        // Four record bytes: status/x high, x low, id/y high, y low
        if (crd_r != 3'd0) rb_nxt[crd_r[1:0] - 2'd1] = ram_rdata;
        if (crd_r == 3'd4) begin
          state_nxt = S_MX;
        end else begin
          crd_nxt = crd_r + 3'd1;
        end
      end

      S_MX: begin
        px_nxt    = mir_val;
        under_nxt = mir_under;
        over_nxt  = mir_over;
        state_nxt = S_MY;
      end

      S_MY: begin
        py_nxt    = mir_val;
        under_nxt = under_r || mir_under;
        over_nxt  = over_r || mir_over;
        state_nxt = S_CEMIT;
      end

      S_CEMIT: begin
        if (resume_r && under_r) begin
          state_nxt = S_IGN;
        end else if (out_free) begin
          emit      = 1'b1;
          e_kind    = EV_CONTACT;
          e_slot    = rb_r[2][7:4];
          index_nxt = index_r + FCNT_W'(1);
          slot_nxt  = slot_r + FCNT_W'(1);
          any_nxt   = 1'b1;
          state_nxt = S_WALK;
        end
      end

      S_DONE: begin
        if (!any_r || out_free) begin
          emit   = any_r;
          e_kind = EV_SYNC;
          e_last = 1'b1;
          prior_valid_nxt = cur_valid_r;
          prior_id_nxt    = cur_id_r;
          resume_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      S_IGN: begin
        if (out_free) begin
          emit   = 1'b1;
          e_kind = EV_IGNORED;
          e_last = 1'b1;
          for (int i = 0; i < FINGERS; i++) begin
            prior_valid_nxt[i] = 1'b0;
            prior_id_nxt[i]    = '0;
          end
          resume_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      S_SUSP: begin
        if (out_free) begin
          emit = 1'b1;
          if (slot_r == FCNT_W'(FINGERS)) begin
            e_kind    = EV_SYNC;
            e_last    = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            e_kind   = EV_RELEASE;
            e_slot   = ID_W'(slot_r);
            slot_nxt = slot_r + FCNT_W'(1);
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Output register: load a new word or drop the taken one
    o_kind_nxt = o_kind_r;
    o_slot_nxt = o_slot_r;
    o_px_nxt   = o_px_r;
    o_py_nxt   = o_py_r;
    o_w_nxt    = o_w_r;
    o_oor_nxt  = o_oor_r;
    o_last_nxt = o_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      o_kind_nxt = e_kind;
      o_slot_nxt = e_slot;
      o_last_nxt = e_last;
      if (e_kind == EV_CONTACT) begin
        o_px_nxt  = px_r;
        o_py_nxt  = py_r;
        o_w_nxt   = WIDTH_FIXED;
        o_oor_nxt = under_r || over_r;
      end else begin
        o_px_nxt  = '0;
        o_py_nxt  = '0;
        o_w_nxt   = '0;
        o_oor_nxt = 1'b0;
      end
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      byte_count_r <= '0;
      for (int i = 0; i < FINGERS; i++) begin
        prior_valid_r[i] <= 1'b1;
        prior_id_r[i]    <= '0;
      end
      resume_r    <= 1'b0;
      x_ext_r     <= EXT_W'(4096);
      y_ext_r     <= EXT_W'(4096);
      rdc_r       <= '0;
      slot_r      <= '0;
      index_r     <= '0;
      any_r       <= 1'b0;
      crd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      byte_count_r  <= byte_count_nxt;
      prior_valid_r <= prior_valid_nxt;
      prior_id_r    <= prior_id_nxt;
      resume_r      <= resume_nxt;
      x_ext_r       <= x_ext_nxt;
      y_ext_r       <= y_ext_nxt;
      rdc_r         <= rdc_nxt;
      slot_r        <= slot_nxt;
      index_r       <= index_nxt;
      any_r         <= any_nxt;
      crd_r         <= crd_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_valid_r <= cur_valid_nxt;
    cur_id_r    <= cur_id_nxt;
    b1_nz_r     <= b1_nz_nxt;
    b2_r        <= b2_nxt;
    rb_r        <= rb_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    under_r     <= under_nxt;
    over_r      <= over_nxt;
    o_kind_r    <= o_kind_nxt;
    o_slot_r    <= o_slot_nxt;
    o_px_r      <= o_px_nxt;
    o_py_r      <= o_py_nxt;
    o_w_r       <= o_w_nxt;
    o_oor_r     <= o_oor_nxt;
    o_last_r    <= o_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = o_kind_r;
  assign out_slot         = o_slot_r;
  assign out_pos_x        = o_px_r;
  assign out_pos_y        = o_py_r;
  assign out_touch_width  = o_w_r;
  assign out_out_of_range = o_oor_r;
  assign out_last         = o_last_r;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for touch_frame_slot_tracker_core: drives frame bytes and
// notices, predicts release, contact, sync and frame-ignored words, checks each one.
// Depends on tfst_pkg and the tracker RTL.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tfst_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 120;

  // Function code with no meaning; the tracker drops it
  localparam func_t FN_UNKNOWN = 2'd3;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  slot;
    logic [11:0] px;
    logic [11:0] py;
    logic [7:0]  w;
    logic        oor;
    logic        last;
  } touch_event_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [EXT_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_func;
  logic [7:0] in_frame_byte;
  logic in_frame_end;
  logic out_valid;
  logic out_stall;
  logic [1:0] out_event_kind;
  logic [3:0] out_slot;
  logic [11:0] out_pos_x;
  logic [11:0] out_pos_y;
  logic [7:0] out_touch_width;
  logic out_out_of_range;
  logic out_last;

  touch_frame_slot_tracker_core uut (.*);

  // Shadow state of the tracker
  logic [7:0]  shadow_store [STORE_DEPTH];
  int          shadow_count;
  logic        kept_valid [FINGERS];
  logic [3:0]  kept_id [FINGERS];
  logic        resume_armed;
  logic [12:0] ext_x;
  logic [12:0] ext_y;

  touch_event_t pending_events[$];
  int errors;
  int n_words_in;
  int n_events;
  int n_frames;
  int n_contacts;
  int n_ignored;
  int n_clipped;
  int burst_left;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d words still expected",
               cycles, pending_events.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void push_event(kind_t k, logic [3:0] s, logic [11:0] px,
                                     logic [11:0] py, logic [7:0] w, logic oor,
                                     logic lst);
    touch_event_t ev;
    ev.kind = k; ev.slot = s; ev.px = px; ev.py = py;
    ev.w = w; ev.oor = oor; ev.last = lst;
    pending_events.push_back(ev);
  endfunction

  // extent - v - 1 with clamping; flags set on underflow or overflow
  function automatic logic [11:0] mirror_coord(logic [12:0] extent, logic [11:0] v,
                                               inout logic under, inout logic over);
    int diff;
    diff = int'(extent) - int'(v) - 1;
    if (diff < 0) begin
      under = 1'b1;
      return 12'd0;
    end
    if (diff > 4095) begin
      over = 1'b1;
      return 12'hfff;
    end
    return diff[11:0];
  endfunction

  function automatic void drop_kept_ids();
    for (int i = 0; i < FINGERS; i++) begin
      kept_valid[i] = 1'b0;
      kept_id[i] = 4'd0;
    end
  endfunction

  // Decode the stored frame and queue the run it produces
  function automatic void predict_frame_run();
    logic        cur_valid [FINGERS];
    logic [3:0]  cur_id [FINGERS];
    logic [1:0]  st;
    logic        z0, z1, cur, prev, under, over;
    int          rec, pos, n;
    logic [11:0] x, y, px, py;
    rec = 0;
    n = 0;
    n_frames++;
    for (int i = 0; i < FINGERS; i++) begin
      pos = REC_BASE + REC_SIZE * i;
      st = shadow_store[pos][7:6];
      cur_id[i] = shadow_store[pos + 2][7:4];
      cur_valid[i] = (st == ST_DOWN) || (st == ST_MOVE);
    end
    if (resume_armed) begin
      z0 = cur_valid[0] && cur_id[0] == 4'd0;
      z1 = (FINGERS > 1) && cur_valid[Z1_IDX] && cur_id[Z1_IDX] == 4'd0;
      if ((z0 && z1) || shadow_store[1] != 8'd0 || shadow_store[2] > FINGERS) begin
        drop_kept_ids();
        resume_armed = 1'b0;
        push_event(EV_IGNORED, 0, 0, 0, 0, 0, 1'b1);
        n_ignored++;
        return;
      end
    end
    for (int id = 0; id < FINGERS; id++) begin
      cur = 1'b0;
      prev = 1'b0;
      for (int i = 0; i < FINGERS; i++) begin
        if (cur_valid[i] && cur_id[i] == id) cur = 1'b1;
        if (kept_valid[i] && kept_id[i] == id) prev = 1'b1;
      end
      if (prev && !cur) begin
        push_event(EV_RELEASE, id[3:0], 0, 0, 0, 0, 1'b0);
        n++;
      end else if (cur) begin
        pos = REC_BASE + REC_SIZE * ((rec < FINGERS) ? rec : FINGERS - 1);
        x = {shadow_store[pos][3:0], shadow_store[pos + 1]};
        y = {shadow_store[pos + 2][3:0], shadow_store[pos + 3]};
        under = 1'b0;
        over = 1'b0;
        px = mirror_coord(ext_x, y, under, over);
        py = mirror_coord(ext_y, x, under, over);
        if (resume_armed && under) begin
          drop_kept_ids();
          resume_armed = 1'b0;
          push_event(EV_IGNORED, 0, 0, 0, 0, 0, 1'b1);
          n_ignored++;
          return;
        end
        if (under || over) n_clipped++;
        push_event(EV_CONTACT, shadow_store[pos + 2][7:4], px, py, WIDTH_FIXED,
                   under || over, 1'b0);
        n_contacts++;
        n++;
        rec++;
      end
    end
    if (n > 0) push_event(EV_SYNC, 0, 0, 0, 0, 0, 1'b1);
    for (int i = 0; i < FINGERS; i++) begin
      kept_valid[i] = cur_valid[i];
      kept_id[i] = cur_id[i];
    end
    resume_armed = 1'b0;
  endfunction

  function automatic void predict_word(logic [1:0] f, logic [7:0] b, logic e);
    case (f)
      FN_BYTE: begin
        if (shadow_count < STORE_DEPTH) begin
          shadow_store[shadow_count] = b;
          shadow_count++;
        end
        if (e) begin
          shadow_count = 0;
          predict_frame_run();
        end
      end
      FN_RESUME: resume_armed = 1'b1;
      FN_SUSPEND: begin
        for (int i = 0; i < FINGERS; i++) push_event(EV_RELEASE, i[3:0], 0, 0, 0, 0, 1'b0);
        push_event(EV_SYNC, 0, 0, 0, 0, 0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // Send one word, holding it until accepted; bursts often separated by random gaps
  task automatic send_word(logic [1:0] f, logic [7:0] b, logic e);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_func <= f;
    in_frame_byte <= b;
    in_frame_end <= e;
    do @(posedge clk); while (in_stall);
    n_words_in++;
    predict_word(f, b, e);
  endtask

  task automatic send_bytes(logic [7:0] bytes[$]);
    foreach (bytes[i]) send_word(FN_BYTE, bytes[i], i == bytes.size() - 1);
  endtask

  // Build a frame: well-formed header and records unless noisy
  function automatic void build_frame(output logic [7:0] bytes[$], input bit noisy,
                                      input bit extreme);
    int ids[FINGERS];
    logic [1:0] st;
    logic [3:0] id;
    logic [11:0] x, y;
    int j, t;
    bytes = {};
    for (int i = 0; i < FINGERS; i++) ids[i] = i;
    for (int i = FINGERS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = ids[i]; ids[i] = ids[j]; ids[j] = t;
    end
    bytes.push_back(8'($urandom));
    bytes.push_back((noisy && $urandom_range(0, 1)) ? 8'($urandom) : 8'd0);
    bytes.push_back((noisy && $urandom_range(0, 1)) ? 8'($urandom)
                                                    : 8'($urandom_range(0, FINGERS)));
    for (int r = 0; r < FINGERS; r++) begin
      case ($urandom_range(0, 5))
        0: st = 2'd1;
        1: st = 2'd3;
        2, 3: st = ST_DOWN;
        default: st = ST_MOVE;
      endcase
      id = (noisy || $urandom_range(0, 9) == 0) ? 4'($urandom) : 4'(ids[r]);
      x = 12'($urandom);
      y = 12'($urandom);
      if (extreme || $urandom_range(0, 4) == 0) begin
        x = $urandom_range(0, 1) ? 12'hfff : 12'h000;
        y = $urandom_range(0, 1) ? 12'hfff : 12'h000;
      end
      bytes.push_back({st, 2'($urandom), x[11:8]});
      bytes.push_back(x[7:0]);
      bytes.push_back({id, y[11:8]});
      bytes.push_back(y[7:0]);
      bytes.push_back(8'($urandom));
      bytes.push_back(8'($urandom));
    end
    bytes.push_back(8'($urandom));
  endfunction

  // Trim or extend a frame to a random length
  function automatic void vary_length(inout logic [7:0] bytes[$]);
    case ($urandom_range(0, 5))
      0: bytes = bytes[0:$urandom_range(0, STORE_DEPTH - 2)];
      1: repeat ($urandom_range(1, 6)) bytes.push_back(8'($urandom));
      default: ;
    endcase
  endfunction

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_extents(logic [12:0] xe, logic [12:0] ye);
    cfg_we <= 1'b1;
    cfg_index <= CFG_X_EXTENT;
    cfg_wdata <= xe;
    @(posedge clk);
    ext_x = xe;
    cfg_index <= CFG_Y_EXTENT;
    cfg_wdata <= ye;
    @(posedge clk);
    ext_y = ye;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver stall pattern: free, random, or long stalls, taken in turn from the cycle count
  always @(posedge clk) begin
    case ((cycles / 64) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= ((cycles % 32) < 20);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // Check each accepted word against the oldest expectation
  always @(posedge clk) begin
    touch_event_t exp_ev;
    if (rst_n && out_valid && !out_stall) begin
      n_events++;
      if (pending_events.size() == 0) begin
        $error("unexpected word: kind %0d slot %0d", out_event_kind, out_slot);
        errors++;
      end else begin
        exp_ev = pending_events.pop_front();
        if (out_event_kind !== exp_ev.kind) begin
          $error("event_kind expected %0d got %0d", exp_ev.kind, out_event_kind);
          errors++;
        end
        if (out_slot !== exp_ev.slot) begin
          $error("slot expected %0d got %0d", exp_ev.slot, out_slot);
          errors++;
        end
        if (out_pos_x !== exp_ev.px) begin
          $error("pos_x expected %0d got %0d", exp_ev.px, out_pos_x);
          errors++;
        end
        if (out_pos_y !== exp_ev.py) begin
          $error("pos_y expected %0d got %0d", exp_ev.py, out_pos_y);
          errors++;
        end
        if (out_touch_width !== exp_ev.w) begin
          $error("touch_width expected %0d got %0d", exp_ev.w, out_touch_width);
          errors++;
        end
        if (out_out_of_range !== exp_ev.oor) begin
          $error("out_of_range expected %0d got %0d", exp_ev.oor, out_out_of_range);
          errors++;
        end
        if (out_last !== exp_ev.last) begin
          $error("last expected %0d got %0d", exp_ev.last, out_last);
          errors++;
        end
      end
    end
  end

  // Full first frame so every decoded byte is written, extremes of coordinates; then a short one
  task automatic test_first_frame();
    logic [7:0] bytes[$];
    build_frame(bytes, 1'b0, 1'b1);
    send_bytes(bytes);
    build_frame(bytes, 1'b0, 1'b1);
    bytes[1] = 8'hff;
    send_bytes(bytes[0:5]);
  endtask

  // Suspend, unknown code, and resumes each followed by a bad frame
  task automatic test_notices();
    logic [7:0] bytes[$];
    send_word(FN_SUSPEND, 8'h00, 1'b0);
    send_word(FN_UNKNOWN, 8'hff, 1'b1);
    send_word(FN_RESUME, 8'h00, 1'b1);
    build_frame(bytes, 1'b0, 1'b0);
    bytes[1] = 8'h01;
    send_bytes(bytes);
    send_word(FN_RESUME, 8'h00, 1'b0);
    build_frame(bytes, 1'b0, 1'b0);
    bytes[2] = 8'hff;
    send_bytes(bytes[0:2]);
    send_word(FN_RESUME, 8'h00, 1'b0);
    bytes = {8'h00, 8'h00, 8'h02, 8'h80, 8'h10, 8'h05, 8'h20, 8'h00, 8'h00,
             8'h00, 8'h7f, 8'h0f, 8'hff};
    send_bytes(bytes);
  endtask

  // Small extents force underflow, with and without a resume pending
  task automatic test_extents();
    logic [7:0] bytes[$];
    wait_idle();
    write_extents(13'd1, 13'd1);
    build_frame(bytes, 1'b0, 1'b1);
    send_bytes(bytes);
    send_word(FN_RESUME, 8'h00, 1'b0);
    build_frame(bytes, 1'b0, 1'b1);
    bytes[1] = 8'h00;
    bytes[2] = 8'h01;
    send_bytes(bytes);
    wait_idle();
    write_extents(13'd4096, 13'd1);
    build_frame(bytes, 1'b0, 1'b0);
    send_bytes(bytes);
    wait_idle();
    write_extents(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
  endtask

  // Mostly well-formed frames with random content, some noise and notices
  task automatic test_random_traffic();
    logic [7:0] bytes[$];
    int phase_items;
    phase_items = 0;
    while (n_words_in < 370) begin
      case ($urandom_range(0, 11))
        0: send_word(FN_SUSPEND, 8'($urandom), 1'($urandom));
        1: send_word(FN_RESUME, 8'($urandom), 1'($urandom));
        2: send_word(FN_UNKNOWN, 8'($urandom), 1'($urandom));
        3: begin
          build_frame(bytes, 1'b1, 1'b0);
          vary_length(bytes);
          send_bytes(bytes);
        end
        default: begin
          build_frame(bytes, 1'b0, 1'b0);
          vary_length(bytes);
          send_bytes(bytes);
        end
      endcase
      phase_items++;
      if (phase_items == 12) begin
        phase_items = 0;
        wait_idle();
        case ($urandom_range(0, 3))
          0: write_extents(13'd4096, 13'd4096);
          1: write_extents(13'd1, 13'd4096);
          default: write_extents(13'($urandom_range(1, 4096)),
                                 13'($urandom_range(1, 4096)));
        endcase
      end
    end
  endtask

  initial begin
    cycles = 0;
    errors = 0;
    n_words_in = 0;
    n_events = 0;
    n_frames = 0;
    n_contacts = 0;
    n_ignored = 0;
    n_clipped = 0;
    burst_left = 0;
    for (int i = 0; i < STORE_DEPTH; i++) shadow_store[i] = 8'd0;
    shadow_count = 0;
    for (int i = 0; i < FINGERS; i++) begin
      kept_valid[i] = 1'b1;
      kept_id[i] = 4'd0;
    end
    resume_armed = 1'b0;
    ext_x = 13'd4096;
    ext_y = 13'd4096;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_X_EXTENT;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_func <= FN_BYTE;
    in_frame_byte <= 8'd0;
    in_frame_end <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_frame();
    test_notices();
    test_extents();
    test_random_traffic();

    wait_idle();
    $display("Sent %0d words, %0d frames; checked %0d result words", n_words_in,
             n_frames, n_events);
    $display("Contacts %0d, clipped %0d, frames ignored %0d", n_contacts, n_clipped,
             n_ignored);
    if (errors == 0 && pending_events.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
